// File: hw/rtl/cds_pkg.sv
// ----------------------------------------------------------------------------
// cds_pkg: shared definitions of the concentric disk sample unit
// Widths, fixed-point constants, series divisors and pipeline word types.
// ----------------------------------------------------------------------------
package cds_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int OUT_BITS    = 16;
  localparam int T_FRAC      = 16;
  localparam int T_BITS      = T_FRAC + 1;
  localparam int Q_FRAC      = 30;
  localparam int ANG_BITS    = 30;
  localparam int P_BITS      = 31;
  localparam int RCP_SHIFT   = 31;
  localparam int POLY_STEPS  = 4;
  localparam int POLY_SUBS   = 3;
  localparam int SCALE_SHIFT = SAMPLE_BITS + 14;
  localparam int PROD_BITS   = SAMPLE_BITS + P_BITS;
  localparam int MAG_BITS    = PROD_BITS + 1 - SCALE_SHIFT;

  localparam logic [P_BITS-1:0]   Q30_ONE = P_BITS'(64'd1073741824);
  localparam logic [ANG_BITS-1:0] PIQ4    = ANG_BITS'(64'd843314857);
  localparam logic [2*P_BITS-1:0] RCP_ONE = (2*P_BITS)'(1) << RCP_SHIFT;

  localparam logic [P_BITS-1:0] SIN_DIV [POLY_STEPS] = '{
    P_BITS'(72), P_BITS'(42), P_BITS'(20), P_BITS'(6)
  };
  localparam logic [P_BITS-1:0] COS_DIV [POLY_STEPS] = '{
    P_BITS'(56), P_BITS'(30), P_BITS'(12), P_BITS'(2)
  };

  typedef enum logic [1:0] {
    WEDGE_RIGHT  = 2'd0,
    WEDGE_TOP    = 2'd1,
    WEDGE_LEFT   = 2'd2,
    WEDGE_BOTTOM = 2'd3
  } wedge_t;

  typedef struct packed {
    wedge_t                 wedge;
    logic [SAMPLE_BITS-1:0] r;
    logic                   nneg;
    logic                   zero;
  } side_t;

  typedef struct packed {
    side_t                  side;
    logic [SAMPLE_BITS-1:0] m;
  } sel_t;

  typedef struct packed {
    side_t                  side;
    logic [SAMPLE_BITS-1:0] rem;
    logic [T_BITS-1:0]      q;
  } div_t;

  typedef struct packed {
    side_t               side;
    logic [ANG_BITS-1:0] x;
  } mx_t;

  typedef struct packed {
    side_t               side;
    logic [ANG_BITS-1:0] x;
    logic [ANG_BITS-1:0] x2;
  } ang_t;

  typedef struct packed {
    side_t               side;
    logic [ANG_BITS-1:0] x;
    logic [ANG_BITS-1:0] x2;
    logic [P_BITS-1:0]   sv;
    logic [P_BITS-1:0]   cv;
    logic [2*P_BITS-1:0] sp;
    logic [2*P_BITS-1:0] cp;
  } poly_t;

  typedef struct packed {
    logic [PROD_BITS-1:0] px;
    logic [PROD_BITS-1:0] py;
    logic                 neg_x;
    logic                 neg_y;
    logic                 zero;
  } scale_t;

endpackage

// File: hw/rtl/cds_sample_if.sv
// ----------------------------------------------------------------------------
// cds_sample_if: input channel of the concentric disk sample unit
// One word carries a pair of uniform samples.
// ----------------------------------------------------------------------------
interface cds_sample_if;
  import cds_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] u_first;
  logic [SAMPLE_BITS-1:0] u_second;

  modport source (output valid, output u_first, output u_second, input ready);
  modport sink (input valid, input u_first, input u_second, output ready);
endinterface

// File: hw/rtl/cds_point_if.sv
// ----------------------------------------------------------------------------
// cds_point_if: output channel of the concentric disk sample unit
// One word carries a point on the unit disk in signed Q1.15.
// ----------------------------------------------------------------------------
interface cds_point_if;
  import cds_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] disk_x;
  logic signed [OUT_BITS-1:0] disk_y;

  modport source (output valid, output disk_x, output disk_y, input ready);
  modport sink (input valid, input disk_x, input disk_y, output ready);
endinterface

// File: hw/rtl/concentric_disk_sample_unit.sv
// ----------------------------------------------------------------------------
// concentric_disk_sample_unit: square to disk mapping in fixed point
// Maps a pair of uniform samples to a point on the unit disk through the
// concentric wedge mapping, with a series sine and cosine.
//
//   channel   side   word
//   sample    sink   u_first, u_second (unsigned fractions)
//   point     source disk_x, disk_y (signed Q1.15, +1 saturates)
//
// One word enters per cycle while the pipeline is not stalled, and passes one
// wedge select stage, 17 divider stages (one quotient bit each), angle and
// square stages, 12 series stages and the scale and round stages.
// Reset clears the stage valid bits only.
// A stage holds while the one after it is full and stalled; empty stages
// close up, so input is taken during an output stall while bubbles remain.
// ----------------------------------------------------------------------------
module concentric_disk_sample_unit (
  input logic         clk,
  input logic         rst,
  cds_sample_if.sink  sample,
  cds_point_if.source point
);
  import cds_pkg::*;

  localparam int ST_SEL   = 0;
  localparam int ST_DIV   = ST_SEL + 1;
  localparam int ST_MX    = ST_DIV + T_BITS;
  localparam int ST_X2    = ST_MX + 1;
  localparam int ST_POLY  = ST_X2 + 1;
  localparam int N_POLY   = POLY_STEPS * POLY_SUBS;
  localparam int ST_SCALE = ST_POLY + N_POLY;
  localparam int ST_OUT   = ST_SCALE + 1;
  localparam int N_STAGES = ST_OUT + 1;

  logic [N_STAGES-1:0] vld;
  logic [N_STAGES-1:0] en;
  logic [N_STAGES-1:0] vld_in;

  sel_t   sel_q;
  sel_t   sel_next;
  div_t   div_q [T_BITS];
  mx_t    mx_q;
  mx_t    mx_next;
  ang_t   x2_q;
  ang_t   x2_next;
  poly_t  poly_q [N_POLY];
  scale_t scale_q;
  scale_t scale_next;

  logic signed [OUT_BITS-1:0] out_x;
  logic signed [OUT_BITS-1:0] out_y;
  logic signed [OUT_BITS-1:0] out_x_next;
  logic signed [OUT_BITS-1:0] out_y_next;

  function automatic logic [OUT_BITS-1:0] round_sat(logic [PROD_BITS-1:0] p, logic neg);
    logic [PROD_BITS:0]    sum;
    logic [MAG_BITS-1:0]   mag;
    logic [MAG_BITS-1:0]   lim;
    logic [OUT_BITS-1:0]   mag_o;
    sum   = {1'b0, p} + ((PROD_BITS + 1)'(1) << (SCALE_SHIFT - 1));
    mag   = sum[SCALE_SHIFT +: MAG_BITS];
    lim   = neg ? (MAG_BITS'(1) << (OUT_BITS - 1))
                : ((MAG_BITS'(1) << (OUT_BITS - 1)) - MAG_BITS'(1));
    mag_o = (mag > lim) ? lim[OUT_BITS-1:0] : mag[OUT_BITS-1:0];
    return neg ? (~mag_o + OUT_BITS'(1)) : mag_o;
  endfunction

  // handshake and valid bits
  assign vld_in = {vld[N_STAGES-2:0], sample.valid};

  genvar gi;
  generate
    for (gi = 0; gi < N_STAGES - 1; gi++) begin : g_en
      assign en[gi] = ~vld[gi] | en[gi+1];
    end
  endgenerate
  assign en[N_STAGES-1] = ~vld[N_STAGES-1] | point.ready;

  assign sample.ready = en[ST_SEL];
  assign point.valid  = vld[ST_OUT];
  assign point.disk_x = out_x;
  assign point.disk_y = out_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (en & vld_in) | (~en & vld);
    end
  end

  // wedge select
  always_comb begin
    logic signed [SAMPLE_BITS:0] sxe;
    logic signed [SAMPLE_BITS:0] sye;
    logic signed [SAMPLE_BITS:0] neg_sy;
    logic signed [SAMPLE_BITS:0] r_s;
    logic signed [SAMPLE_BITS:0] n_s;
    logic signed [SAMPLE_BITS:0] m_s;
    logic                        ge;
    logic                        gt;
    sxe    = {~sample.u_first[SAMPLE_BITS-1], ~sample.u_first[SAMPLE_BITS-1],
              sample.u_first[SAMPLE_BITS-2:0]};
    sye    = {~sample.u_second[SAMPLE_BITS-1], ~sample.u_second[SAMPLE_BITS-1],
              sample.u_second[SAMPLE_BITS-2:0]};
    neg_sy = -sye;
    ge     = sxe >= neg_sy;
    gt     = sxe > sye;
    unique case ({ge, gt})
      2'b11: begin
        sel_next.side.wedge = WEDGE_RIGHT;
        r_s = sxe;
        n_s = sye;
      end
      2'b10: begin
        sel_next.side.wedge = WEDGE_TOP;
        r_s = sye;
        n_s = sxe;
      end
      2'b00: begin
        sel_next.side.wedge = WEDGE_LEFT;
        r_s = -sxe;
        n_s = sye;
      end
      default: begin
        sel_next.side.wedge = WEDGE_BOTTOM;
        r_s = -sye;
        n_s = sxe;
      end
    endcase
    m_s = n_s[SAMPLE_BITS] ? -n_s : n_s;
    sel_next.side.r    = r_s[SAMPLE_BITS-1:0];
    sel_next.side.nneg = n_s[SAMPLE_BITS];
    sel_next.side.zero = (sxe == '0) && (sye == '0);
    sel_next.m         = m_s[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[ST_SEL]) begin
      sel_q <= sel_next;
    end
  end

  // ratio divider, one quotient bit a stage
  generate
    for (gi = 0; gi < T_BITS; gi++) begin : g_div
      logic [SAMPLE_BITS-1:0] rem_in;
      logic                   bit_in;
      logic [T_BITS-1:0]      q_in;
      side_t                  side_in;
      logic [SAMPLE_BITS:0]   trial;
      logic [SAMPLE_BITS:0]   diff;
      logic                   take;
      div_t                   nxt;

      if (gi == 0) begin : g_first
        assign rem_in  = sel_q.m >> 1;
        assign bit_in  = sel_q.m[0];
        assign q_in    = '0;
        assign side_in = sel_q.side;
      end else begin : g_rest
        assign rem_in  = div_q[gi-1].rem;
        assign bit_in  = 1'b0;
        assign q_in    = div_q[gi-1].q;
        assign side_in = div_q[gi-1].side;
      end

      always_comb begin
        trial = {rem_in, bit_in};
        diff  = trial - {1'b0, side_in.r};
        take  = trial >= {1'b0, side_in.r};
        nxt.side = side_in;
        nxt.rem  = take ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
        nxt.q    = q_in;
        nxt.q[T_BITS-1-gi] = take;
      end

      always_ff @(posedge clk) begin
        if (en[ST_DIV+gi]) begin
          div_q[gi] <= nxt;
        end
      end
    end
  endgenerate

  // angle in eighths of a turn to radians
  always_comb begin
    logic [T_BITS+ANG_BITS-1:0] prod;
    prod = {{ANG_BITS{1'b0}}, div_q[T_BITS-1].q} * {{T_BITS{1'b0}}, PIQ4};
    mx_next.side = div_q[T_BITS-1].side;
    mx_next.x    = prod[T_FRAC +: ANG_BITS];
  end

  always_ff @(posedge clk) begin
    if (en[ST_MX]) begin
      mx_q <= mx_next;
    end
  end

  // angle squared
  always_comb begin
    logic [2*ANG_BITS-1:0] sq;
    sq = {{ANG_BITS{1'b0}}, mx_q.x} * {{ANG_BITS{1'b0}}, mx_q.x};
    x2_next.side = mx_q.side;
    x2_next.x    = mx_q.x;
    x2_next.x2   = sq[Q_FRAC +: ANG_BITS];
  end

  always_ff @(posedge clk) begin
    if (en[ST_X2]) begin
      x2_q <= x2_next;
    end
  end

  // horner series: reciprocal multiply, correct and subtract, multiply back
  generate
    for (gi = 0; gi < N_POLY; gi++) begin : g_poly
      localparam int STEP = gi / POLY_SUBS;
      localparam int SUB  = gi % POLY_SUBS;
      localparam logic [P_BITS-1:0] SD = SIN_DIV[STEP];
      localparam logic [P_BITS-1:0] CD = COS_DIV[STEP];
      localparam logic [P_BITS-1:0] SRCP = P_BITS'(RCP_ONE / SD);
      localparam logic [P_BITS-1:0] CRCP = P_BITS'(RCP_ONE / CD);

      poly_t prev;
      poly_t nxt;

      if (gi == 0) begin : g_head
        always_comb begin
          prev.side = x2_q.side;
          prev.x    = x2_q.x;
          prev.x2   = x2_q.x2;
          prev.sv   = {1'b0, x2_q.x2};
          prev.cv   = {1'b0, x2_q.x2};
          prev.sp   = '0;
          prev.cp   = '0;
        end
      end else begin : g_link
        assign prev = poly_q[gi-1];
      end

      if (SUB == 0) begin : g_rcp
        always_comb begin
          nxt    = prev;
          nxt.sp = {{P_BITS{1'b0}}, prev.sv} * {{P_BITS{1'b0}}, SRCP};
          nxt.cp = {{P_BITS{1'b0}}, prev.cv} * {{P_BITS{1'b0}}, CRCP};
        end
      end else if (SUB == 1) begin : g_fix
        always_comb begin
          logic [P_BITS-1:0] sq0;
          logic [P_BITS-1:0] cq0;
          logic [P_BITS-1:0] srem;
          logic [P_BITS-1:0] crem;
          logic [P_BITS-1:0] sq;
          logic [P_BITS-1:0] cq;
          sq0  = prev.sp[RCP_SHIFT +: P_BITS];
          cq0  = prev.cp[RCP_SHIFT +: P_BITS];
          srem = prev.sv - sq0 * SD;
          crem = prev.cv - cq0 * CD;
          sq   = (srem >= SD) ? sq0 + P_BITS'(1) : sq0;
          cq   = (crem >= CD) ? cq0 + P_BITS'(1) : cq0;
          nxt    = prev;
          nxt.sv = Q30_ONE - sq;
          nxt.cv = Q30_ONE - cq;
        end
      end else begin : g_mul
        logic [ANG_BITS-1:0] sop;
        if (STEP == POLY_STEPS - 1) begin : g_last
          assign sop = prev.x;
        end else begin : g_mid
          assign sop = prev.x2;
        end
        always_comb begin
          logic [ANG_BITS+P_BITS-1:0] sprod;
          logic [ANG_BITS+P_BITS-1:0] cprod;
          sprod = {{P_BITS{1'b0}}, sop} * {{ANG_BITS{1'b0}}, prev.sv};
          cprod = {{P_BITS{1'b0}}, prev.x2} * {{ANG_BITS{1'b0}}, prev.cv};
          nxt    = prev;
          nxt.sv = sprod[Q_FRAC +: P_BITS];
          nxt.cv = (STEP == POLY_STEPS - 1) ? prev.cv : cprod[Q_FRAC +: P_BITS];
        end
      end

      always_ff @(posedge clk) begin
        if (en[ST_POLY+gi]) begin
          poly_q[gi] <= nxt;
        end
      end
    end
  endgenerate

  // radius scale
  always_comb begin
    logic [P_BITS-1:0] tx;
    logic [P_BITS-1:0] ty;
    side_t             sd;
    sd = poly_q[N_POLY-1].side;
    unique case (sd.wedge)
      WEDGE_RIGHT: begin
        tx = poly_q[N_POLY-1].cv;
        ty = poly_q[N_POLY-1].sv;
        scale_next.neg_x = 1'b0;
        scale_next.neg_y = sd.nneg;
      end
      WEDGE_TOP: begin
        tx = poly_q[N_POLY-1].sv;
        ty = poly_q[N_POLY-1].cv;
        scale_next.neg_x = sd.nneg;
        scale_next.neg_y = 1'b0;
      end
      WEDGE_LEFT: begin
        tx = poly_q[N_POLY-1].cv;
        ty = poly_q[N_POLY-1].sv;
        scale_next.neg_x = 1'b1;
        scale_next.neg_y = sd.nneg;
      end
      default: begin
        tx = poly_q[N_POLY-1].sv;
        ty = poly_q[N_POLY-1].cv;
        scale_next.neg_x = sd.nneg;
        scale_next.neg_y = 1'b1;
      end
    endcase
    scale_next.px   = {{P_BITS{1'b0}}, sd.r} * {{SAMPLE_BITS{1'b0}}, tx};
    scale_next.py   = {{P_BITS{1'b0}}, sd.r} * {{SAMPLE_BITS{1'b0}}, ty};
    scale_next.zero = sd.zero;
  end

  always_ff @(posedge clk) begin
    if (en[ST_SCALE]) begin
      scale_q <= scale_next;
    end
  end

  // round, saturate, sign
  always_comb begin
    if (scale_q.zero) begin
      out_x_next = '0;
      out_y_next = '0;
    end else begin
      out_x_next = round_sat(scale_q.px, scale_q.neg_x);
      out_y_next = round_sat(scale_q.py, scale_q.neg_y);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_x <= out_x_next;
      out_y <= out_y_next;
    end
  end

endmodule
